[src/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants and control types for the set-associative LRU cache core.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

   localparam int unsigned OPCODE_W   = 2;
   localparam int unsigned OUTCOME_W  = 2;
   localparam int unsigned TOTAL_W    = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 6;

   // configuration register widths and tag shift width
   localparam int unsigned SET_BITS_W = 3;
   localparam int unsigned OFFSET_W   = 6;
   localparam int unsigned WAYS_W     = 4;
   localparam int unsigned SHIFT_W    = 7;

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_STORE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_MODIFY = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NONE   = 2'd3;

   // access outcomes
   localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS     = 2'd2;

   localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 3'd0;
   localparam logic [OFFSET_W-1:0]   OFFSET_RST   = 6'd4;
   localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;

   typedef struct packed {
      logic capture;     // latch tag/set, read the set row
      logic clear_step;  // clear one row of the tag store
      logic update;      // look up, write back row, load result
      logic last;        // final result of this request
   } salc_cmd_type;

   typedef struct packed {
      logic clear_done;
   } salc_status_type;

endpackage

`default_nettype wire

[src/salc_req_if.sv]
// ----------------------------------------------------------------------------
// salc_req_if
// Request channel: opcode and byte address with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface salc_req_if
   import salc_pkg::*;
#(
   parameter int unsigned ADDR_WIDTH = 64
) ();
   logic                  valid;
   logic                  ready;
   logic [OPCODE_W-1:0]   opcode;
   logic [ADDR_WIDTH-1:0] address;

   modport source (output valid, output opcode, output address, input ready);
   modport sink   (input valid, input opcode, input address, output ready);
endinterface

`default_nettype wire

[src/salc_rsp_if.sv]
// ----------------------------------------------------------------------------
// salc_rsp_if
// Result channel: access outcome and running totals with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface salc_rsp_if
   import salc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic                 last_of_run;
   logic [TOTAL_W-1:0]   hit_total;
   logic [TOTAL_W-1:0]   miss_total;
   logic [TOTAL_W-1:0]   eviction_total;

   modport source (output valid, output outcome, output last_of_run, output hit_total,
                   output miss_total, output eviction_total, input ready);
   modport sink   (input valid, input outcome, input last_of_run, input hit_total,
                   input miss_total, input eviction_total, output ready);
endinterface

`default_nettype wire

[src/set_associative_lru_cache_sim_core.sv]
// ----------------------------------------------------------------------------
// set_associative_lru_cache_sim_core
// Tag-store model of a set-associative cache with LRU replacement.
// ----------------------------------------------------------------------------
// Each request reads one set row of the tag store into the row register when
// it is accepted, then resolves hit, fill or eviction in its update step,
// writing the row back and loading the result register: a load or store makes
// one access, a modify two (its second access reuses the row just written), and
// opcode 3 is accepted with no result. Each access has its own update step; a
// full result register holds the update until the result is taken. After reset
// the core clears the tag store one row a cycle, all 2**MAX_SET_BITS rows (2
// when MAX_SET_BITS is 0), with req_chan.ready low; configuration writes are
// taken throughout.
`default_nettype none

module set_associative_lru_cache_sim_core
   import salc_pkg::*;
#(
   parameter int unsigned MAX_SET_BITS = 6,
   parameter int unsigned MAX_WAYS     = 8,
   parameter int unsigned ADDR_WIDTH   = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   salc_req_if.sink                   req_chan,
   salc_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   salc_cmd_type    cmd;
   salc_status_type status;

   salc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .cmd        (cmd),
      .status     (status)
   );

   salc_dpath #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_address        (req_chan.address),
      .rsp_outcome        (rsp_chan.outcome),
      .rsp_last_of_run    (rsp_chan.last_of_run),
      .rsp_hit_total      (rsp_chan.hit_total),
      .rsp_miss_total     (rsp_chan.miss_total),
      .rsp_eviction_total (rsp_chan.eviction_total)
   );

endmodule

`default_nettype wire

[src/salc_ctrl.sv]
// ----------------------------------------------------------------------------
// salc_ctrl
// Controller: tag store clear after reset, request sequencing, result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_ctrl
   import salc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [OPCODE_W-1:0] req_opcode,
   output logic                     req_ready,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output salc_cmd_type             cmd,
   input  wire salc_status_type     status
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      modify_ff, modify_in;
   logic      second_ff, second_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      modify_in    = modify_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (req_opcode != OP_NONE)) begin
               cmd.capture = 1'b1;
               modify_in   = (req_opcode == OP_MODIFY);
               second_in   = 1'b0;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               cmd.update   = 1'b1;
               cmd.last     = !modify_ff || second_ff;
               rsp_valid_in = 1'b1;
               if (cmd.last) begin
                  state_in = ST_IDLE;
               end else begin
                  // second access of a modify works on the forwarded row
                  second_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         modify_ff    <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modify_ff    <= modify_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[src/salc_dpath.sv]
// ----------------------------------------------------------------------------
// salc_dpath
// Datapath: configuration registers, address split, tag store memories,
// hit/fill/victim selection, LRU rank update and saturating totals.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_dpath
   import salc_pkg::*;
#(
   parameter int unsigned MAX_SET_BITS = 6,
   parameter int unsigned MAX_WAYS     = 8,
   parameter int unsigned ADDR_WIDTH   = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire salc_cmd_type          cmd,
   output salc_status_type            status,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [ADDR_WIDTH-1:0] req_address,
   output logic [OUTCOME_W-1:0]       rsp_outcome,
   output logic                       rsp_last_of_run,
   output logic [TOTAL_W-1:0]         rsp_hit_total,
   output logic [TOTAL_W-1:0]         rsp_miss_total,
   output logic [TOTAL_W-1:0]         rsp_eviction_total
);

   localparam int unsigned SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int unsigned ROWS     = 1 << SET_W;
   localparam int unsigned RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int unsigned RANK_MAX = MAX_WAYS - 1;

   typedef logic [MAX_WAYS-1:0]                 valid_row_type;
   typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_row_type;
   typedef logic [MAX_WAYS-1:0][RANK_W-1:0]     rank_row_type;

   // tag store, one row per set
   valid_row_type mem_valid [ROWS];
   tag_row_type   mem_tag   [ROWS];
   rank_row_type  mem_rank  [ROWS];

   logic [SET_BITS_W-1:0] cfg_sets_ff, cfg_sets_in;
   logic [OFFSET_W-1:0]   cfg_off_ff, cfg_off_in;
   logic [WAYS_W-1:0]     cfg_ways_ff, cfg_ways_in;

   logic [SET_W-1:0]      clr_ff, clr_in;
   logic [SET_W-1:0]      set_ff;
   logic [ADDR_WIDTH-1:0] tag_ff;
   valid_row_type         row_valid_ff, row_valid_in;
   tag_row_type           row_tag_ff, row_tag_in;
   rank_row_type          row_rank_ff, row_rank_in;

   logic [TOTAL_W-1:0]    hits_ff, hits_in;
   logic [TOTAL_W-1:0]    misses_ff, misses_in;
   logic [TOTAL_W-1:0]    evicts_ff, evicts_in;
   logic [OUTCOME_W-1:0]  outcome_ff;
   logic                  last_ff;

   logic [SET_BITS_W-1:0] sb_eff;
   logic [SHIFT_W-1:0]    tag_shift;
   logic [ADDR_WIDTH-1:0] off_shifted;
   logic [ADDR_WIDTH-1:0] tag_calc;
   logic [SET_W:0]        one_shifted;
   logic [SET_W:0]        mask_wide;
   logic [SET_W-1:0]      set_calc;

   logic [MAX_WAYS-1:0]   way_on;
   logic [MAX_WAYS-1:0]   hit_vec;
   logic [MAX_WAYS-1:0]   empty_vec;
   logic                  found;
   logic                  have_empty;
   logic [RANK_W-1:0]     hit_idx;
   logic [RANK_W-1:0]     empty_idx;
   logic [RANK_W-1:0]     victim_idx;
   logic [RANK_W-1:0]     pick;
   logic [RANK_W-1:0]     old_rank;
   logic                  old_is_max;
   logic [OUTCOME_W-1:0]  outcome;
   valid_row_type         new_valid;
   tag_row_type           new_tag;
   rank_row_type          new_rank;

   assign status.clear_done = (clr_ff == {SET_W{1'b1}});

   // ---------------- configuration ----------------
   always_comb begin
      cfg_sets_in = cfg_sets_ff;
      cfg_off_in  = cfg_off_ff;
      cfg_ways_in = cfg_ways_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SET_BITS: cfg_sets_in = csr_wdata[SET_BITS_W-1:0];
            CSR_OFFSET:   cfg_off_in  = csr_wdata[OFFSET_W-1:0];
            CSR_WAYS:     cfg_ways_in = csr_wdata[WAYS_W-1:0];
            default:      cfg_sets_in = cfg_sets_ff;
         endcase
      end
   end

   // ---------------- address split ----------------
   always_comb begin
      sb_eff      = (32'(cfg_sets_ff) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS)
                                                      : cfg_sets_ff;
      tag_shift   = SHIFT_W'(cfg_off_ff) + SHIFT_W'(sb_eff);
      off_shifted = req_address >> cfg_off_ff;
      tag_calc    = req_address >> tag_shift;
      one_shifted = (SET_W + 1)'(1) << sb_eff;
      mask_wide   = one_shifted - (SET_W + 1)'(1);
      set_calc    = off_shifted[SET_W-1:0] & mask_wide[SET_W-1:0];
   end

   // ways beyond the configured associativity are ignored; zero acts as one
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         way_on[w] = (32'(w) < 32'(cfg_ways_ff)) || (w == 0);
      end
   end

   // ---------------- lookup and replacement ----------------
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         hit_vec[w]   = way_on[w] && row_valid_ff[w] && (row_tag_ff[w] == tag_ff);
         empty_vec[w] = way_on[w] && !row_valid_ff[w];
      end
      found      = |hit_vec;
      have_empty = |empty_vec;

      hit_idx   = '0;
      empty_idx = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_idx = RANK_W'(w);
         end
         if (empty_vec[w]) begin
            empty_idx = RANK_W'(w);
         end
      end

      // oldest rank, lowest index on ties
      victim_idx = '0;
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (way_on[w] && (row_rank_ff[w] > row_rank_ff[victim_idx])) begin
            victim_idx = RANK_W'(w);
         end
      end

      if (found) begin
         pick    = hit_idx;
         outcome = OUT_HIT;
      end else if (have_empty) begin
         pick    = empty_idx;
         outcome = OUT_FILL;
      end else begin
         pick    = victim_idx;
         outcome = OUT_EVICT;
      end

      // an empty way counts as older than every valid way
      old_is_max = !found && have_empty;
      old_rank   = row_rank_ff[pick];

      new_valid = row_valid_ff;
      new_tag   = row_tag_ff;
      new_rank  = row_rank_ff;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (way_on[w] && row_valid_ff[w] && (RANK_W'(w) != pick)) begin
            if ((old_is_max || (row_rank_ff[w] < old_rank))
                && (32'(row_rank_ff[w]) < RANK_MAX)) begin
               new_rank[w] = row_rank_ff[w] + 1'b1;
            end
         end
      end
      new_valid[pick] = 1'b1;
      new_tag[pick]   = tag_ff;
      new_rank[pick]  = '0;
   end

   // ---------------- row register and totals ----------------
   always_comb begin
      row_valid_in = row_valid_ff;
      row_tag_in   = row_tag_ff;
      row_rank_in  = row_rank_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      clr_in       = clr_ff;
      if (cmd.clear_step) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.update) begin
         // forward the written row so a second access sees it
         row_valid_in = new_valid;
         row_tag_in   = new_tag;
         row_rank_in  = new_rank;
         if (outcome == OUT_HIT) begin
            hits_in = (hits_ff == '1) ? hits_ff : hits_ff + 1'b1;
         end else begin
            misses_in = (misses_ff == '1) ? misses_ff : misses_ff + 1'b1;
         end
         if (outcome == OUT_EVICT) begin
            evicts_in = (evicts_ff == '1) ? evicts_ff : evicts_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sets_ff <= SET_BITS_RST;
         cfg_off_ff  <= OFFSET_RST;
         cfg_ways_ff <= WAYS_RST;
         clr_ff      <= '0;
         hits_ff     <= '0;
         misses_ff   <= '0;
         evicts_ff   <= '0;
      end else begin
         cfg_sets_ff <= cfg_sets_in;
         cfg_off_ff  <= cfg_off_in;
         cfg_ways_ff <= cfg_ways_in;
         clr_ff      <= clr_in;
         hits_ff     <= hits_in;
         misses_ff   <= misses_in;
         evicts_ff   <= evicts_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         set_ff       <= set_calc;
         tag_ff       <= tag_calc;
         row_valid_ff <= mem_valid[set_calc];
         row_tag_ff   <= mem_tag[set_calc];
         row_rank_ff  <= mem_rank[set_calc];
      end else begin
         row_valid_ff <= row_valid_in;
         row_tag_ff   <= row_tag_in;
         row_rank_ff  <= row_rank_in;
      end
      if (cmd.update) begin
         outcome_ff <= outcome;
         last_ff    <= cmd.last;
      end
   end

   // tag store write port
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem_valid[clr_ff] <= '0;
         mem_rank[clr_ff]  <= '0;
      end else if (cmd.update) begin
         mem_valid[set_ff] <= new_valid;
         mem_tag[set_ff]   <= new_tag;
         mem_rank[set_ff]  <= new_rank;
      end
   end

   assign rsp_outcome        = outcome_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_hit_total      = hits_ff;
   assign rsp_miss_total     = misses_ff;
   assign rsp_eviction_total = evicts_ff;

endmodule

`default_nettype wire

[src/salc_checker.sv]
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks on the result channel of the cache core.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_checker
   import salc_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [OUTCOME_W-1:0] rsp_outcome,
   input wire logic                 rsp_last_of_run,
   input wire logic [TOTAL_W-1:0]   rsp_hit_total,
   input wire logic [TOTAL_W-1:0]   rsp_miss_total,
   input wire logic [TOTAL_W-1:0]   rsp_eviction_total
);

   // a stalled result stays valid with its outcome, last flag and hit total held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome)
         && $stable(rsp_last_of_run) && $stable(rsp_hit_total))
      else $error("result changed while stalled");

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_outcome == OUT_HIT) || (rsp_outcome == OUT_FILL)
         || (rsp_outcome == OUT_EVICT))
      else $error("unknown outcome code");

   // an eviction is a miss, so both totals are already counted
   a_evict_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == OUT_EVICT) |->
         (rsp_eviction_total != '0) && (rsp_miss_total != '0))
      else $error("eviction result with empty totals");

   a_totals_grow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) && !$past(reset) |->
         (rsp_hit_total >= $past(rsp_hit_total))
         && (rsp_miss_total >= $past(rsp_miss_total))
         && (rsp_eviction_total >= $past(rsp_eviction_total)))
      else $error("running total went down");

endmodule

bind set_associative_lru_cache_sim_core salc_checker u_salc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_outcome        (rsp_chan.outcome),
   .rsp_last_of_run    (rsp_chan.last_of_run),
   .rsp_hit_total      (rsp_chan.hit_total),
   .rsp_miss_total     (rsp_chan.miss_total),
   .rsp_eviction_total (rsp_chan.eviction_total)
);

`default_nettype wire

[tb/salc_tb_pkg.sv]
// ----------------------------------------------------------------------------
// salc_tb_pkg
// LRU tag-store predictor and result scoreboard for the cache core testbench.
// ----------------------------------------------------------------------------
package salc_tb_pkg;

   import salc_pkg::*;

   localparam int unsigned MAX_SET_BITS = 6;
   localparam int unsigned MAX_WAYS     = 8;
   localparam int unsigned ADDR_WIDTH   = 64;
   localparam int unsigned NUM_LINES    = (1 << MAX_SET_BITS) * MAX_WAYS;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic                 last;
      logic [TOTAL_W-1:0]   hits;
      logic [TOTAL_W-1:0]   misses;
      logic [TOTAL_W-1:0]   evictions;
   } cache_result_type;

   class lru_cache_checker;
      bit                  line_valid [NUM_LINES];
      logic [63:0]         line_tag   [NUM_LINES];
      logic [2:0]          line_rank  [NUM_LINES];
      logic [TOTAL_W-1:0]  hits_seen;
      logic [TOTAL_W-1:0]  misses_seen;
      logic [TOTAL_W-1:0]  evictions_seen;
      logic [SET_BITS_W-1:0] set_bits;
      logic [OFFSET_W-1:0]   offset_bits;
      logic [WAYS_W-1:0]     ways_cfg;
      cache_result_type    expected_results [$];
      int unsigned         failures;

      function new();
         foreach (line_valid[i]) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_rank[i]  = '0;
         end
         hits_seen      = '0;
         misses_seen    = '0;
         evictions_seen = '0;
         set_bits       = SET_BITS_RST;
         offset_bits    = OFFSET_RST;
         ways_cfg       = WAYS_RST;
         failures       = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_SET_BITS: set_bits    = data[SET_BITS_W-1:0];
            CSR_OFFSET:   offset_bits = data[OFFSET_W-1:0];
            CSR_WAYS:     ways_cfg    = data[WAYS_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      // One access against the tag store; returns the outcome code.
      function logic [OUTCOME_W-1:0] access_line(logic [63:0] address);
         int unsigned          sb, nw, base, pick, w, i, shift, old_rank;
         logic [63:0]          a, set_idx, tag;
         bit                   found, have_empty;
         logic [OUTCOME_W-1:0] result;
         sb = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : set_bits;
         nw = (ways_cfg == 0) ? 1 : ((ways_cfg > MAX_WAYS) ? MAX_WAYS : ways_cfg);
         a = (ADDR_WIDTH >= 64) ? address : (address & ((64'd1 << ADDR_WIDTH) - 1));
         set_idx = (offset_bits >= 64) ? 64'd0 : (a >> offset_bits);
         set_idx = set_idx & ((64'd1 << sb) - 1);
         shift = offset_bits + sb;
         tag = (shift >= 64) ? 64'd0 : (a >> shift);
         base = 32'(set_idx) * MAX_WAYS;
         found = 1'b0;
         pick = 0;
         for (w = 0; w < nw; w++) begin
            if (!found && line_valid[base+w] && line_tag[base+w] == tag) begin
               pick  = w;
               found = 1'b1;
            end
         end
         if (found) begin
            hits_seen = bump(hits_seen);
            result = OUT_HIT;
         end else begin
            misses_seen = bump(misses_seen);
            have_empty = 1'b0;
            for (w = 0; w < nw; w++) begin
               if (!have_empty && !line_valid[base+w]) begin
                  pick = w;
                  have_empty = 1'b1;
               end
            end
            if (!have_empty) begin
               // oldest rank wins, lowest way on a tie
               pick = 0;
               for (w = 1; w < nw; w++)
                  if (line_rank[base+w] > line_rank[base+pick]) pick = w;
               evictions_seen = bump(evictions_seen);
               result = OUT_EVICT;
            end else begin
               result = OUT_FILL;
            end
         end
         // an empty way counts as older than everything
         old_rank = (result == OUT_FILL) ? 255 : line_rank[base+pick];
         for (w = 0; w < nw; w++) begin
            i = base + w;
            if (w != pick && line_valid[i] && line_rank[i] < old_rank &&
                line_rank[i] < MAX_WAYS - 1)
               line_rank[i] = line_rank[i] + 1'b1;
         end
         line_valid[base+pick] = 1'b1;
         line_tag[base+pick]   = tag;
         line_rank[base+pick]  = '0;
         return result;
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [63:0] address);
         cache_result_type r;
         if (op == OP_NONE) return;
         r.outcome   = access_line(address);
         r.last      = (op != OP_MODIFY);
         r.hits      = hits_seen;
         r.misses    = misses_seen;
         r.evictions = evictions_seen;
         expected_results.push_back(r);
         if (op == OP_MODIFY) begin
            r.outcome   = access_line(address);
            r.last      = 1'b1;
            r.hits      = hits_seen;
            r.misses    = misses_seen;
            r.evictions = evictions_seen;
            expected_results.push_back(r);
         end
      endfunction

      function void check_result(cache_result_type got);
         cache_result_type want;
         if (expected_results.size() == 0) begin
            $error("result with no request pending: outcome %0d", got.outcome);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         if (got.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, got.last);
            failures++;
         end
         if (got.hits !== want.hits) begin
            $error("hit_total: expected %0d, got %0d", want.hits, got.hits);
            failures++;
         end
         if (got.misses !== want.misses) begin
            $error("miss_total: expected %0d, got %0d", want.misses, got.misses);
            failures++;
         end
         if (got.evictions !== want.evictions) begin
            $error("eviction_total: expected %0d, got %0d", want.evictions, got.evictions);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction
   endclass

endpackage

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives loads, stores and modifies into the LRU cache core across many
// geometries and checks every outcome and running total against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import salc_pkg::*;
   import salc_tb_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bit          req_fast = 1'b0;
   bit          rsp_fast = 1'b0;
   int unsigned hold_off = 0;

   lru_cache_checker board = new();

   salc_req_if #(.ADDR_WIDTH(ADDR_WIDTH)) req_bus ();
   salc_rsp_if rsp_bus ();

   set_associative_lru_cache_sim_core #(
      .MAX_SET_BITS(MAX_SET_BITS),
      .MAX_WAYS    (MAX_WAYS),
      .ADDR_WIDTH  (ADDR_WIDTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      cache_result_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            board.note_request(req_bus.opcode, req_bus.address);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.outcome   = rsp_bus.outcome;
            got.last      = rsp_bus.last_of_run;
            got.hits      = rsp_bus.hit_total;
            got.misses    = rsp_bus.miss_total;
            got.evictions = rsp_bus.eviction_total;
            board.check_result(got);
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : result_sink
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = rsp_fast ? 0 : $urandom_range(0, 15);
         if (hold_off != 0) begin
            stall = hold_off;
            hold_off = 0;
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   task automatic send_request(logic [OPCODE_W-1:0] op, logic [63:0] address);
      int unsigned gap;
      gap = req_fast ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= op;
      req_bus.address <= address;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // drain all outstanding results, then let a trailing no-op request clear
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_W-1:0];
      board.write_reg(index, value[CSR_DATA_W-1:0]);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(int unsigned sb, int unsigned off, int unsigned ways);
      settle();
      write_reg(CSR_SET_BITS, sb);
      write_reg(CSR_OFFSET, off);
      write_reg(CSR_WAYS, ways);
   endtask

   initial begin : stimulus
      int unsigned        phase, k, n_tags, n_sets, sb_cfg, off_cfg, ways_cfg;
      int unsigned        sb_eff, nw_eff, shift, pick;
      logic [63:0]        tag_pool [10];
      logic [63:0]        set_pool [3];
      logic [63:0]        address;
      logic [OPCODE_W-1:0] op;

      req_bus.valid   = 1'b0;
      req_bus.opcode  = OP_LOAD;
      req_bus.address = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_SET_BITS;
      csr_wdata = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset geometry: one set, one way, 16-byte blocks
      send_request(OP_LOAD, 64'h0);
      send_request(OP_STORE, 64'h8);
      send_request(OP_MODIFY, 64'h10);
      send_request(OP_NONE, 64'h0);
      send_request(OP_LOAD, '1);
      configure(0, 4, 2);
      send_request(OP_LOAD, 64'h0);
      // shrink to one way: way 0 gets replaced, leaving two lines of rank 0
      configure(0, 4, 1);
      send_request(OP_LOAD, 64'h20);
      configure(0, 4, 2);
      send_request(OP_LOAD, 64'h30);
      configure(0, 4, 0);
      send_request(OP_LOAD, 64'h30);
      // oversized settings saturate; tag shift runs past the address
      configure(7, 63, 15);
      send_request(OP_LOAD, 64'h0);
      send_request(OP_STORE, 64'h8000_0000_0000_0000);
      send_request(OP_MODIFY, '1);
      configure(6, 0, 8);
      send_request(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFC0);
      send_request(OP_MODIFY, 64'h0000_0000_0000_003F);
      send_request(OP_STORE, 64'hA5A5_5A5A_0F0F_F0F0);
      send_request(OP_NONE, '1);
      configure(6, 58, 8);
      send_request(OP_LOAD, 64'h0400_0000_0000_0000);
      send_request(OP_LOAD, 64'hFC00_0000_0000_0001);

      for (phase = 0; phase < 12; phase++) begin
         sb_cfg   = $urandom_range(0, 7);
         off_cfg  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
         ways_cfg = $urandom_range(0, 15);
         configure(sb_cfg, off_cfg, ways_cfg);
         sb_eff = (sb_cfg > MAX_SET_BITS) ? MAX_SET_BITS : sb_cfg;
         nw_eff = (ways_cfg == 0) ? 1 : ((ways_cfg > MAX_WAYS) ? MAX_WAYS : ways_cfg);
         shift  = off_cfg + sb_eff;
         // one or two more tags than ways per set keeps hits and evictions both frequent
         n_tags = nw_eff + $urandom_range(1, 2);
         n_sets = $urandom_range(1, 3);
         foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
         foreach (set_pool[i]) set_pool[i] = $urandom_range(0, 63) & ((64'd1 << sb_eff) - 1);
         req_fast = ($urandom_range(0, 3) == 0);
         rsp_fast = ($urandom_range(0, 3) == 0);
         if (phase == 3) begin
            req_fast = 1'b1;
            hold_off = 250;
         end
         for (k = 0; k < 80; k++) begin
            pick = $urandom_range(0, 12);
            if (pick == 0)      op = OP_NONE;
            else if (pick <= 4) op = OP_LOAD;
            else if (pick <= 8) op = OP_STORE;
            else                op = OP_MODIFY;
            if ($urandom_range(0, 9) == 0) begin
               address = {$urandom, $urandom};
            end else begin
               address = {$urandom, $urandom} & ((64'd1 << off_cfg) - 1);
               address = address | (set_pool[$urandom_range(0, n_sets - 1)] << off_cfg);
               if (shift < 64)
                  address = address | (tag_pool[$urandom_range(0, n_tags - 1)] << shift);
            end
            send_request(op, address);
         end
      end

      settle();
      repeat (10) @(negedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[filelist.f]
src/salc_pkg.sv
src/salc_req_if.sv
src/salc_rsp_if.sv
src/salc_ctrl.sv
src/salc_dpath.sv
src/set_associative_lru_cache_sim_core.sv
src/salc_checker.sv
tb/salc_tb_pkg.sv
tb/tb_top.sv
